// File: design/wsp_pkg.sv
package wsp_pkg;

  localparam int CAPACITY  = 256;
  localparam int ITEM_BITS = 16;

  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_PICK = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [0:0] REG_WINDOW_LIMIT = 1'b0;
  localparam logic [0:0] REG_RANDOM_SEED  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MOD,
    S_RD,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WAPPEND,
    S_HEAD_RD,
    S_WSHIFT_RD,
    S_WSHIFT_WR,
    S_POOL_APPEND,
    S_DONE
  } state_t;

endpackage

// File: design/wsp_modu.sv
// shift-subtract remainder: one quotient bit per cycle
module wsp_modu #(
  parameter int DW = 32,
  parameter int NW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] remainder
);
  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dvd;
  logic [NW:0]   rem;
  logic [NW-1:0] dsr;
  logic [CW-1:0] cnt;
  logic          run;
  logic [NW:0]   trial;
  logic [NW:0]   rem_next;

  always_comb begin
    trial = {rem[NW-1:0], dvd[DW-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = trial - {1'b0, dsr};
    end else begin
      rem_next = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DW);
        rem <= '0;
        dvd <= dividend;
        dsr <= divisor;
      end else if (run) begin
        rem <= rem_next;
        dvd <= {dvd[DW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[NW-1:0];
endmodule

// File: design/windowed_shuffle_picker.sv
// channel   | direction | signals
// request   | in/out    | start, cmd, item_id in; busy out
// result    | out       | done, picked_item, item_count, status
// config    | in/out    | cfg_valid, cfg_index, cfg_data in; cfg_ready out
//
// an add or an empty pick holds busy through S_CHECK and S_DONE; done rises in the
// cycle after S_DONE; a pick runs the modulo unit once per refill step plus a read and
// a write state per pool entry shifted, then a head read plus a read and a write state
// per window entry shifted; alternating shift read and write states set the shift cost
// rst is synchronous; counts clear, lfsr loads seed 1, window limit 7
// done pulses for one cycle; the receiver cannot stall
module windowed_shuffle_picker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic [15:0] item_id,
  output logic        done,
  output logic [15:0] picked_item,
  output logic [8:0]  item_count,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import wsp_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CNW = $clog2(CAPACITY + 1);

  // storage
  logic [ITEM_BITS-1:0] pool_mem [CAPACITY];
  logic [ITEM_BITS-1:0] win_mem  [CAPACITY];

  state_t state, state_next;

  logic [7:0]           window_limit;
  logic [31:0]          lfsr;
  logic [CNW-1:0]       pool_count;
  logic [CNW-1:0]       window_count;
  logic                 cmd_r;
  logic [ITEM_BITS-1:0] id_r;
  logic [CNW-1:0]       idx;       // shift pointer
  logic [ITEM_BITS-1:0] rd_data;   // registered pool read
  logic [ITEM_BITS-1:0] wrd_data;  // registered window read
  logic [ITEM_BITS-1:0] taken;     // removed or picked id
  logic                 prev_rd;   // last cycle was S_RD
  logic                 prev_head; // last cycle was S_HEAD_RD

  // pool port
  logic                 p_we;
  logic [AW-1:0]        p_waddr;
  logic [AW-1:0]        p_raddr;
  logic [ITEM_BITS-1:0] p_wdata;
  // window port
  logic                 w_we;
  logic [AW-1:0]        w_waddr;
  logic [AW-1:0]        w_raddr;
  logic [ITEM_BITS-1:0] w_wdata;

  logic        mod_start;
  logic        mod_done;
  logic [CNW-1:0] mod_rem;
  logic [31:0] lfsr_step;
  logic [CNW:0] total;
  logic        refill_ok;

  assign lfsr_step = lfsr[0] ? ({1'b0, lfsr[31:1]} ^ LFSR_TAPS) : {1'b0, lfsr[31:1]};
  assign total     = {1'b0, pool_count} + {1'b0, window_count};
  assign refill_ok = (window_count <= CNW'(window_limit)) &&
                     (pool_count != '0) && (window_count < CNW'(CAPACITY));

  // the remainder is taken of the stepped generator value
  wsp_modu #(.DW(32), .NW(CNW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (lfsr_step),
    .divisor   (pool_count),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // memories
  always_ff @(posedge clk) begin
    if (p_we) begin
      pool_mem[p_waddr] <= p_wdata;
    end
    rd_data <= pool_mem[p_raddr];
    if (w_we) begin
      win_mem[w_waddr] <= w_wdata;
    end
    wrd_data <= win_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    mod_start  = 1'b0;
    p_we       = 1'b0;
    p_waddr    = idx[AW-1:0];
    p_raddr    = idx[AW-1:0];
    p_wdata    = rd_data;
    w_we       = 1'b0;
    w_waddr    = window_count[AW-1:0];
    w_raddr    = idx[AW-1:0];
    w_wdata    = taken;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cmd_r == CMD_ADD) begin
          if (total >= (CNW + 1)'(CAPACITY)) begin
            state_next = S_DONE;
          end else begin
            p_we       = 1'b1;
            p_waddr    = pool_count[AW-1:0];
            p_wdata    = id_r;
            state_next = S_DONE;
          end
        end else if (total == '0) begin
          state_next = S_DONE;
        end else if (refill_ok) begin
          state_next = S_MOD;
          mod_start  = 1'b1;
        end else begin
          state_next = S_HEAD_RD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        // read the removed entry, idx holds remainder
        state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        // rd_data holds pool[idx]; latch in taken on first pass, then read idx+1
        p_raddr = AW'(idx + 1'b1);
        if (idx + 1'b1 >= pool_count) begin
          state_next = S_WAPPEND;
        end else begin
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        p_we       = 1'b1;
        p_wdata    = rd_data;
        state_next = S_SHIFT_RD;
      end
      S_WAPPEND: begin
        w_we    = 1'b1;
        w_waddr = window_count[AW-1:0];
        w_wdata = taken;
        state_next = S_CHECK;
      end
      S_HEAD_RD: begin
        w_raddr    = '0;
        state_next = S_WSHIFT_RD;
      end
      S_WSHIFT_RD: begin
        w_raddr = AW'(idx + 1'b1);
        if (idx + 1'b1 >= window_count) begin
          state_next = S_POOL_APPEND;
        end else begin
          state_next = S_WSHIFT_WR;
        end
      end
      S_WSHIFT_WR: begin
        w_we       = 1'b1;
        w_waddr    = idx[AW-1:0];
        w_wdata    = wrd_data;
        state_next = S_WSHIFT_RD;
      end
      S_POOL_APPEND: begin
        p_we       = 1'b1;
        p_waddr    = pool_count[AW-1:0];
        p_wdata    = taken;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit <= 8'd7;
      lfsr         <= 32'd1;
      pool_count   <= '0;
      window_count <= '0;
      done         <= 1'b0;
      picked_item  <= '0;
      item_count   <= '0;
      status       <= ST_OK;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_LIMIT: window_limit <= cfg_data[7:0];
          REG_RANDOM_SEED:  lfsr <= (cfg_data == 32'd0) ? 32'd1 : cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            id_r  <= ITEM_BITS'(item_id);
            picked_item <= '0;
            status      <= ST_OK;
          end
        end
        S_CHECK: begin
          if (cmd_r == CMD_ADD) begin
            if (total >= (CNW + 1)'(CAPACITY)) begin
              status <= ST_FULL;
            end else begin
              pool_count <= pool_count + 1'b1;
            end
          end else if (total == '0) begin
            status <= ST_EMPTY;
          end else if (refill_ok) begin
            // advance now; the modulo unit takes the stepped value
            lfsr <= lfsr_step;
          end else begin
            idx <= '0;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            idx <= mod_rem;
          end
        end
        S_SHIFT_RD: begin
          if (state_next == S_WAPPEND) begin
            pool_count <= pool_count - 1'b1;
          end
        end
        S_SHIFT_WR: begin
          idx <= idx + 1'b1;
        end
        S_WAPPEND: begin
          window_count <= window_count + 1'b1;
        end
        S_WSHIFT_RD: begin
          if (state_next == S_POOL_APPEND) begin
            window_count <= window_count - 1'b1;
          end
        end
        S_WSHIFT_WR: begin
          idx <= idx + 1'b1;
        end
        S_POOL_APPEND: begin
          pool_count  <= pool_count + 1'b1;
          picked_item <= 16'(taken);
        end
        S_DONE: begin
          done       <= 1'b1;
          item_count <= 9'(total);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prev_rd   <= (state == S_RD);
    prev_head <= (state == S_HEAD_RD);
  end

  // removed id: first read after the index settles
  always_ff @(posedge clk) begin
    if (state == S_SHIFT_RD && prev_rd) begin
      taken <= rd_data;
    end else if (state == S_WSHIFT_RD && prev_head) begin
      taken <= wrd_data;
    end
  end

endmodule

// File: verif/windowed_shuffle_picker_test.sv
module windowed_shuffle_picker_test;
  import wsp_pkg::*;

  localparam int POOL_CAP = 256;

  // one expected pick/add outcome
  typedef struct packed {
    logic [15:0] picked_item;
    logic [8:0]  item_count;
    logic [1:0]  status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd = CMD_ADD;
  logic [15:0] item_id = '0;
  logic        done;
  logic [15:0] picked_item;
  logic [8:0]  item_count;
  logic [1:0]  status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = REG_WINDOW_LIMIT;
  logic [31:0] cfg_data = '0;

  windowed_shuffle_picker u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .item_id(item_id),
    .done(done), .picked_item(picked_item), .item_count(item_count), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the block state
  logic [15:0] pool_q[$];
  logic [15:0] window_q[$];
  logic [31:0] lfsr_state;
  logic [7:0]  limit_shadow;
  outcome_t    pending_q[$];
  int          mismatches = 0;

  function automatic logic [31:0] lfsr_next(logic [31:0] v);
    logic [31:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

  // shuffle behavior of one accepted request
  function automatic outcome_t shuffle_outcome(logic c, logic [15:0] id);
    outcome_t o;
    int       total;
    int       idx;
    o = '0;
    total = pool_q.size() + window_q.size();
    if (c == CMD_ADD) begin
      if (total >= POOL_CAP) o.status = ST_FULL;
      else pool_q.push_back(id);
    end else if (total == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // refill the window from random pool slots, order of the rest kept
      while (window_q.size() <= int'(limit_shadow) && pool_q.size() > 0 &&
             window_q.size() < POOL_CAP) begin
        lfsr_state = lfsr_next(lfsr_state);
        idx = int'(lfsr_state % pool_q.size());
        window_q.push_back(pool_q[idx]);
        pool_q.delete(idx);
      end
      if (window_q.size() > 0) begin
        o.picked_item = window_q.pop_front();
        if (pool_q.size() < POOL_CAP) pool_q.push_back(o.picked_item);
      end
    end
    o.item_count = 9'(pool_q.size() + window_q.size());
    return o;
  endfunction

  // result checker, sampled mid-cycle
  always @(negedge clk) begin
    outcome_t exp_o;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %h %0d %0d",
                                       picked_item, item_count, status);
      end else begin
        exp_o = pending_q.pop_front();
        if (exp_o.picked_item !== picked_item || exp_o.item_count !== item_count ||
            exp_o.status !== status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp item %h count %0d status %0d, got %h %0d %0d",
                     exp_o.picked_item, exp_o.item_count, exp_o.status,
                     picked_item, item_count, status);
        end
      end
    end
  end

  // send one request; called and returns at a rising edge
  task automatic send_request(logic c, logic [15:0] id);
    cmd     <= c;
    item_id <= id;
    start   <= 1'b1;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    pending_q.push_back(shuffle_outcome(c, id));
    @(posedge clk);
  endtask

  // gap between bursts; zero length keeps start high
  task automatic idle_gap(int n);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // hold off until every expected result is back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    if (idx == REG_WINDOW_LIMIT) begin
      limit_shadow = data[7:0];
    end else begin
      // a zero seed would lock the generator, so it loads as one
      lfsr_state = (data == 0) ? 32'd1 : data;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random burst/gap pacing for the sender
  int burst_left = 0;
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
    end
  endtask

  // empty pick, id extremes, default and corner settings, zero seed
  task automatic test_directed();
    send_request(CMD_PICK, 16'h1234);
    send_request(CMD_ADD, 16'h0000);
    send_request(CMD_ADD, 16'hFFFF);
    send_request(CMD_ADD, 16'hA5A5);
    send_request(CMD_ADD, 16'h5A5A);
    repeat (5) send_request(CMD_PICK, 16'hFFFF);
    write_reg(REG_WINDOW_LIMIT, 32'd0);
    write_reg(REG_RANDOM_SEED, 32'd0);
    repeat (4) send_request(CMD_PICK, 16'h0000);
    write_reg(REG_RANDOM_SEED, 32'hFFFF_FFFF);
    write_reg(REG_WINDOW_LIMIT, 32'd255);
    send_request(CMD_ADD, 16'h8001);
    repeat (4) send_request(CMD_PICK, 16'h0000);
    write_reg(REG_WINDOW_LIMIT, 32'd1);
    repeat (3) send_request(CMD_PICK, 16'h0000);
  endtask

  // mostly picks with slow growth of the store, several settings
  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_reg(REG_WINDOW_LIMIT, 32'd7);
        1: write_reg(REG_WINDOW_LIMIT, 32'($urandom_range(0, 255) << 8));
        2: write_reg(REG_WINDOW_LIMIT, 32'd2);
        3: write_reg(REG_WINDOW_LIMIT, 32'(($urandom & 32'hFFFF_FF00) | 32'd255));
        default: write_reg(REG_WINDOW_LIMIT, 32'($urandom_range(0, 15)));
      endcase
      write_reg(REG_RANDOM_SEED, $urandom | 32'd1);
      for (int n = 0; n < 300; n++) begin
        if ($urandom_range(0, 99) < 10) send_request(CMD_ADD, 16'($urandom));
        else send_request(CMD_PICK, 16'($urandom));
        if (n == 150) drain_results();
        else pace();
      end
    end
  endtask

  // fill to capacity, overflow, then picks from a full store
  task automatic test_full();
    write_reg(REG_WINDOW_LIMIT, 32'd3);
    while (pool_q.size() + window_q.size() < POOL_CAP)
      send_request(CMD_ADD, 16'($urandom));
    send_request(CMD_ADD, 16'hFFFF);
    send_request(CMD_ADD, 16'h0000);
    repeat (6) send_request(CMD_PICK, 16'h0000);
    write_reg(REG_WINDOW_LIMIT, 32'd255);
    repeat (3) send_request(CMD_PICK, 16'h0000);
    send_request(CMD_ADD, 16'h1111);
  endtask

  initial begin
    limit_shadow = 8'd7;
    lfsr_state   = 32'd1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_full();
    drain_results();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("windowed_shuffle_picker_test: done, clean");
    end else begin
      $display("windowed_shuffle_picker_test: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("windowed_shuffle_picker_test: done, errors");
    $finish;
  end

endmodule
